// ----- design/sdu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subevent unpacker package
// Shared constants, parser modes, command and back-end types.
// ----------------------------------------------------------------------------
package sdu_pkg;

    localparam int CHANNEL_COUNT = 8;
    localparam int SCALER_COUNT  = 10;
    localparam int DUMP_COUNT    = 2 * CHANNEL_COUNT + SCALER_COUNT;
    localparam int DUMP_IDX_W    = $clog2(DUMP_COUNT);

    localparam int WORD_W    = 16;
    localparam int VALUE_W   = 32;
    localparam int ADC_VAL_W = 12;
    localparam int KIND_W    = 2;
    localparam int CHAN_W    = 4;
    localparam int CH_SEL_W  = 3;
    localparam int WL_W      = 4;
    localparam int M_TDATA_W = 40;
    localparam int PAD_W     = M_TDATA_W - KIND_W - CHAN_W - VALUE_W;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    localparam logic [WORD_W-1:0]    HDR_ADC      = 16'h1007;
    localparam logic [WORD_W-1:0]    HDR_TDC      = 16'h2005;
    localparam logic [WORD_W-1:0]    HDR_SCALER   = 16'h3801;
    localparam logic [ADC_VAL_W-1:0] VAL_OVERFLOW = 12'hfff;
    localparam logic [WL_W-1:0]      SCALER_SKIP  = 4'd2;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_ADC_CNT,
        MODE_TDC_CNT,
        MODE_ADC_DAT,
        MODE_TDC_DAT,
        MODE_SCAL_PAIR,
        MODE_SCAL_SKIP,
        MODE_SCAL_LO,
        MODE_SCAL_HI
    } parse_mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADC    = 2'd0,
        KIND_TDC    = 2'd1,
        KIND_SCALER = 2'd2
    } source_kind_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_ADC,
        CMD_TDC,
        CMD_SCALER
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t             op;
        logic [CHAN_W-1:0]   idx;
        logic [VALUE_W-1:0]  value;
        logic                dump;
    } cmd_t;

    typedef enum logic {
        BACK_IDLE,
        BACK_DUMP
    } back_state_t;

endpackage

// ----- design/sdu_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subevent unpacker parser
// Accepts payload words, tracks the section layout and issues store and
// dump commands to the command queue.
// ----------------------------------------------------------------------------
module sdu_front
    import sdu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [WORD_W-1:0] s_tdata,
    input  logic              s_tlast,
    input  logic              fifo_full,
    output cmd_t              cmd,
    output logic              cmd_push
);

    parse_mode_t           mode_reg, mode_next;
    logic [WL_W-1:0]       wl_reg, wl_next;
    logic [CHAN_W-1:0]     sidx_reg, sidx_next;
    logic [WORD_W-1:0]     low_reg, low_next;
    logic                  skip_reg, skip_next;

    logic                  accept;
    logic                  end_now;
    logic [CH_SEL_W-1:0]   ch;
    logic [ADC_VAL_W-1:0]  adc_v;
    logic [WL_W-1:0]       wl_dec;
    logic [CHAN_W-1:0]     sidx_inc;

    assign s_tready = !fifo_full;
    assign accept   = s_tvalid && s_tready;
    assign ch       = s_tdata[14:12];
    assign adc_v    = (s_tdata[ADC_VAL_W-1:0] == VAL_OVERFLOW) ? '0 : s_tdata[ADC_VAL_W-1:0];
    assign wl_dec   = (wl_reg != '0) ? WL_W'(wl_reg - 1'b1) : '0;
    assign sidx_inc = CHAN_W'(sidx_reg + 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            wl_reg   <= '0;
            sidx_reg <= '0;
            low_reg  <= '0;
            skip_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            wl_reg   <= wl_next;
            sidx_reg <= sidx_next;
            low_reg  <= low_next;
            skip_reg <= skip_next;
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        wl_next   = wl_reg;
        sidx_next = sidx_reg;
        low_next  = low_reg;
        skip_next = skip_reg;
        end_now   = 1'b0;
        cmd.op    = CMD_NONE;
        cmd.idx   = '0;
        cmd.value = '0;
        cmd.dump  = 1'b0;
        if (accept)
        begin
            if (skip_reg)
            begin
                if (s_tlast)
                begin
                    skip_next = 1'b0;
                end
            end
            else
            begin
                case (mode_reg)
                    MODE_IDLE:
                    begin
                        if (s_tdata == '0)
                        begin
                            end_now = 1'b1;
                        end
                        else if (s_tdata == HDR_ADC)
                        begin
                            mode_next = MODE_ADC_CNT;
                        end
                        else if (s_tdata == HDR_TDC)
                        begin
                            mode_next = MODE_TDC_CNT;
                        end
                        else if (s_tdata == HDR_SCALER)
                        begin
                            mode_next = MODE_SCAL_PAIR;
                        end
                    end
                    MODE_ADC_CNT, MODE_TDC_CNT:
                    begin
                        if (s_tdata[15])
                        begin
                            wl_next   = WL_W'({1'b0, ch} + 1'b1);
                            mode_next = (mode_reg == MODE_ADC_CNT) ? MODE_ADC_DAT
                                                                   : MODE_TDC_DAT;
                        end
                        else
                        begin
                            mode_next = MODE_IDLE;
                        end
                    end
                    MODE_ADC_DAT, MODE_TDC_DAT:
                    begin
                        if (int'(ch) < CHANNEL_COUNT)
                        begin
                            cmd.op    = (mode_reg == MODE_ADC_DAT) ? CMD_ADC : CMD_TDC;
                            cmd.idx   = CHAN_W'(ch);
                            cmd.value = VALUE_W'(adc_v);
                        end
                        wl_next = wl_dec;
                        if (wl_dec == '0)
                        begin
                            mode_next = MODE_IDLE;
                        end
                    end
                    MODE_SCAL_PAIR:
                    begin
                        if (s_tdata == '0)
                        begin
                            mode_next = MODE_SCAL_SKIP;
                            wl_next   = SCALER_SKIP;
                        end
                        else
                        begin
                            mode_next = MODE_IDLE;
                        end
                    end
                    MODE_SCAL_SKIP:
                    begin
                        wl_next = wl_dec;
                        if (wl_dec == '0)
                        begin
                            mode_next = MODE_SCAL_LO;
                            sidx_next = '0;
                        end
                    end
                    MODE_SCAL_LO:
                    begin
                        low_next  = s_tdata;
                        mode_next = MODE_SCAL_HI;
                    end
                    MODE_SCAL_HI:
                    begin
                        if (int'(sidx_reg) < SCALER_COUNT)
                        begin
                            cmd.op    = CMD_SCALER;
                            cmd.idx   = sidx_reg;
                            cmd.value = {s_tdata, low_reg};
                        end
                        if ((int'(sidx_inc) >= SCALER_COUNT) || (sidx_inc == '0))
                        begin
                            mode_next = MODE_IDLE;
                            sidx_next = '0;
                        end
                        else
                        begin
                            mode_next = MODE_SCAL_LO;
                            sidx_next = sidx_inc;
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_IDLE;
                    end
                endcase
                if (end_now || s_tlast)
                begin
                    cmd.dump  = 1'b1;
                    mode_next = MODE_IDLE;
                    wl_next   = '0;
                    sidx_next = '0;
                    low_next  = '0;
                    if (end_now && !s_tlast)
                    begin
                        skip_next = 1'b1;
                    end
                end
            end
        end
    end

    assign cmd_push = accept && ((cmd.op != CMD_NONE) || cmd.dump);

endmodule

// ----- design/sdu_cmd_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subevent unpacker command queue
// Short register queue that decouples the parser from the store back end.
// ----------------------------------------------------------------------------
module sdu_cmd_fifo
    import sdu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic empty
);

    cmd_t                  entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = FIFO_CNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = FIFO_CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= FIFO_PTR_W'(wr_ptr_reg + 1'b1);
            end
            if (pop)
            begin
                rd_ptr_reg <= FIFO_PTR_W'(rd_ptr_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("Command queue written while full.");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("Command queue read while empty.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= FIFO_DEPTH)
        else $error("Command queue count out of range.");
`endif

endmodule

// ----- design/sdu_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subevent unpacker back end
// Holds the ADC, TDC and scaler stores, applies queued writes and streams
// the dump through a registered output stage.
// ----------------------------------------------------------------------------
module sdu_back
    import sdu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 head,
    input  logic                 empty,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    back_state_t             state_reg, state_next;
    logic [DUMP_IDX_W-1:0]   dump_idx_reg, dump_idx_next;
    logic [ADC_VAL_W-1:0]    adc_reg    [CHANNEL_COUNT];
    logic [ADC_VAL_W-1:0]    tdc_reg    [CHANNEL_COUNT];
    logic [VALUE_W-1:0]      scaler_reg [SCALER_COUNT];

    logic                    out_valid_reg;
    source_kind_t            out_kind_reg;
    logic [CHAN_W-1:0]       out_chan_reg;
    logic [VALUE_W-1:0]      out_value_reg;
    logic                    out_last_reg;

    logic                    out_free;
    logic                    load;
    logic                    clear;
    source_kind_t            rd_kind;
    logic [CHAN_W-1:0]       rd_chan;
    logic [VALUE_W-1:0]      rd_value;
    logic [DUMP_IDX_W-1:0]   tdc_off;
    logic [DUMP_IDX_W-1:0]   scal_off;

    assign out_free = !out_valid_reg || m_tready;
    assign tdc_off  = DUMP_IDX_W'(dump_idx_reg - DUMP_IDX_W'(CHANNEL_COUNT));
    assign scal_off = DUMP_IDX_W'(dump_idx_reg - DUMP_IDX_W'(2 * CHANNEL_COUNT));

    always_comb
    begin
        if (int'(dump_idx_reg) < CHANNEL_COUNT)
        begin
            rd_kind  = KIND_ADC;
            rd_chan  = CHAN_W'(dump_idx_reg);
            rd_value = VALUE_W'(adc_reg[dump_idx_reg[CH_SEL_W-1:0]]);
        end
        else if (int'(dump_idx_reg) < 2 * CHANNEL_COUNT)
        begin
            rd_kind  = KIND_TDC;
            rd_chan  = CHAN_W'(tdc_off);
            rd_value = VALUE_W'(tdc_reg[tdc_off[CH_SEL_W-1:0]]);
        end
        else
        begin
            rd_kind  = KIND_SCALER;
            rd_chan  = CHAN_W'(scal_off);
            rd_value = scaler_reg[scal_off[CHAN_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BACK_IDLE;
            dump_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            dump_idx_reg <= dump_idx_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        dump_idx_next = dump_idx_reg;
        pop           = 1'b0;
        load          = 1'b0;
        clear         = 1'b0;
        case (state_reg)
            BACK_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    if (head.dump)
                    begin
                        state_next    = BACK_DUMP;
                        dump_idx_next = '0;
                    end
                end
            end
            BACK_DUMP:
            begin
                if (out_free)
                begin
                    load = 1'b1;
                    if (dump_idx_reg == DUMP_IDX_W'(DUMP_COUNT - 1))
                    begin
                        clear      = 1'b1;
                        state_next = BACK_IDLE;
                    end
                    else
                    begin
                        dump_idx_next = DUMP_IDX_W'(dump_idx_reg + 1'b1);
                    end
                end
            end
            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                adc_reg[i] <= '0;
                tdc_reg[i] <= '0;
            end
            for (int i = 0; i < SCALER_COUNT; i++)
            begin
                scaler_reg[i] <= '0;
            end
        end
        else if (clear)
        begin
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                adc_reg[i] <= '0;
                tdc_reg[i] <= '0;
            end
            for (int i = 0; i < SCALER_COUNT; i++)
            begin
                scaler_reg[i] <= '0;
            end
        end
        else if (pop)
        begin
            case (head.op)
                CMD_ADC:
                begin
                    adc_reg[head.idx[CH_SEL_W-1:0]] <= head.value[ADC_VAL_W-1:0];
                end
                CMD_TDC:
                begin
                    tdc_reg[head.idx[CH_SEL_W-1:0]] <= head.value[ADC_VAL_W-1:0];
                end
                CMD_SCALER:
                begin
                    scaler_reg[head.idx] <= head.value;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_kind_reg  <= rd_kind;
            out_chan_reg  <= rd_chan;
            out_value_reg <= rd_value;
            out_last_reg  <= clear;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_value_reg, out_chan_reg, out_kind_reg};
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_dump_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BACK_DUMP) |-> (int'(dump_idx_reg) < DUMP_COUNT))
        else $error("Dump index out of range.");

    a_no_pop_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BACK_DUMP) |-> !pop)
        else $error("Command taken during a dump.");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (load && clear) |=> (state_reg == BACK_IDLE && m_tvalid && m_tlast
                             && adc_reg[0] == '0 && scaler_reg[0] == '0))
        else $error("Stores not cleared after the final dump transaction.");
`endif

endmodule

// ----- design/detector_subevent_unpacker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Detector subevent unpacker
// Parses ADC, TDC and scaler sections of a subevent and dumps all values.
// ----------------------------------------------------------------------------
// Payload words are taken one per cycle while the four-entry command queue
// has room. The last word of a subevent, or a zero word between sections,
// starts a dump of 26 transactions (8 ADC, 8 TDC, 10 scaler values), one
// per cycle from the store back end while the receiver is ready, with
// tlast on the final one; during a dump the queue fills and then holds off
// the input.
module detector_subevent_unpacker
    import sdu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [WORD_W-1:0]    s_tdata,   // data_word
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // source_kind, channel, value, zero pad
    output logic                 m_tlast
);

    cmd_t push_cmd;
    cmd_t head;
    logic push;
    logic pop;
    logic full;
    logic empty;

    sdu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .fifo_full (full),
        .cmd       (push_cmd),
        .cmd_push  (push)
    );

    sdu_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    sdu_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- sim/detector_subevent_unpacker_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Detector subevent unpacker testbench
// Feeds payload words with directed sections, early ends and random
// subevents, predicts every dumped value and checks each output transaction
// field by field, under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module detector_subevent_unpacker_tb;
    import sdu_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_WORDS = 74;

    typedef struct packed {
        source_kind_t       kind;
        logic [CHAN_W-1:0]  channel;
        logic [VALUE_W-1:0] value;
        logic               last;
    } dump_value_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [WORD_W-1:0]    s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    dump_value_t       pending_values[$];
    logic [WORD_W-1:0] subevent_words[$];
    int                error_count;
    int                quiet_cycles;
    int                words_sent;
    int                send_idle_pct;
    int                stall_pct;

    parse_mode_t          mode;
    logic [WL_W-1:0]      words_left;
    logic [ADC_VAL_W-1:0] adc_store [CHANNEL_COUNT];
    logic [ADC_VAL_W-1:0] tdc_store [CHANNEL_COUNT];
    logic [VALUE_W-1:0]   scaler_store [SCALER_COUNT];
    logic [3:0]           scaler_idx;
    logic [WORD_W-1:0]    low_half;
    logic                 skip_to_end;

    detector_subevent_unpacker u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void clear_parser();
        for (int i = 0; i < CHANNEL_COUNT; i++)
        begin
            adc_store[i] = '0;
            tdc_store[i] = '0;
        end
        for (int i = 0; i < SCALER_COUNT; i++)
            scaler_store[i] = '0;
        mode       = MODE_IDLE;
        words_left = '0;
        scaler_idx = '0;
        low_half   = '0;
    endfunction

    function automatic void queue_dump();
        dump_value_t v;
        v.last = 1'b0;
        for (int i = 0; i < CHANNEL_COUNT; i++)
        begin
            v.kind    = KIND_ADC;
            v.channel = CHAN_W'(i);
            v.value   = VALUE_W'(adc_store[i]);
            pending_values.push_back(v);
        end
        for (int i = 0; i < CHANNEL_COUNT; i++)
        begin
            v.kind    = KIND_TDC;
            v.channel = CHAN_W'(i);
            v.value   = VALUE_W'(tdc_store[i]);
            pending_values.push_back(v);
        end
        for (int i = 0; i < SCALER_COUNT; i++)
        begin
            v.kind    = KIND_SCALER;
            v.channel = CHAN_W'(i);
            v.value   = scaler_store[i];
            v.last    = (i == SCALER_COUNT - 1);
            pending_values.push_back(v);
        end
        clear_parser();
    endfunction

    function automatic void store_data(input logic is_tdc, input logic [WORD_W-1:0] w);
        logic [CH_SEL_W-1:0]  ch;
        logic [ADC_VAL_W-1:0] v;
        ch = w[14:12];
        v  = w[11:0];
        if (v == VAL_OVERFLOW)
            v = '0;
        if (ch < CHANNEL_COUNT)
        begin
            if (is_tdc)
                tdc_store[ch] = v;
            else
                adc_store[ch] = v;
        end
        if (words_left > 0)
            words_left--;
        if (words_left == 0)
            mode = MODE_IDLE;
    endfunction

    function automatic void count_word(input logic [WORD_W-1:0] w, input parse_mode_t data_mode);
        if (w[15])
        begin
            words_left = WL_W'(w[14:12]) + 1'b1;
            mode       = data_mode;
        end
        else
            mode = MODE_IDLE;
    endfunction

    function automatic void predict_word(input logic [WORD_W-1:0] w, input logic l);
        logic end_now;
        end_now = 1'b0;
        if (skip_to_end)
        begin
            if (l)
                skip_to_end = 1'b0;
            return;
        end
        case (mode)
            MODE_IDLE:
            begin
                if (w == '0)
                    end_now = 1'b1;
                else if (w == HDR_ADC)
                    mode = MODE_ADC_CNT;
                else if (w == HDR_TDC)
                    mode = MODE_TDC_CNT;
                else if (w == HDR_SCALER)
                    mode = MODE_SCAL_PAIR;
            end
            MODE_ADC_CNT: count_word(w, MODE_ADC_DAT);
            MODE_TDC_CNT: count_word(w, MODE_TDC_DAT);
            MODE_ADC_DAT: store_data(1'b0, w);
            MODE_TDC_DAT: store_data(1'b1, w);
            MODE_SCAL_PAIR:
            begin
                if (w == '0)
                begin
                    mode       = MODE_SCAL_SKIP;
                    words_left = SCALER_SKIP;
                end
                else
                    mode = MODE_IDLE;
            end
            MODE_SCAL_SKIP:
            begin
                if (words_left > 0)
                    words_left--;
                if (words_left == 0)
                begin
                    mode       = MODE_SCAL_LO;
                    scaler_idx = '0;
                end
            end
            MODE_SCAL_LO:
            begin
                low_half = w;
                mode     = MODE_SCAL_HI;
            end
            MODE_SCAL_HI:
            begin
                if (scaler_idx < SCALER_COUNT)
                    scaler_store[scaler_idx] = {w, low_half};
                scaler_idx = scaler_idx + 1'b1;
                if (scaler_idx >= SCALER_COUNT || scaler_idx == 0)
                begin
                    mode       = MODE_IDLE;
                    scaler_idx = '0;
                end
                else
                    mode = MODE_SCAL_LO;
            end
            default: mode = MODE_IDLE;
        endcase
        if (end_now || l)
        begin
            if (end_now && !l)
                skip_to_end = 1'b1;
            queue_dump();
        end
    endfunction

    function automatic void check_value(input logic [M_TDATA_W-1:0] data, input logic last);
        dump_value_t        want;
        logic [KIND_W-1:0]  kind;
        logic [CHAN_W-1:0]  chan;
        logic [VALUE_W-1:0] value;
        kind  = data[KIND_W-1:0];
        chan  = data[KIND_W +: CHAN_W];
        value = data[KIND_W + CHAN_W +: VALUE_W];
        if (pending_values.size() == 0)
        begin
            $display("%0t: unexpected transaction kind %0d channel %0d value 0x%08h last %0b",
                     $time, kind, chan, value, last);
            error_count++;
            return;
        end
        want = pending_values.pop_front();
        if (kind !== want.kind)
        begin
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind);
            error_count++;
        end
        if (chan !== want.channel)
        begin
            $display("%0t: channel expected %0d actual %0d", $time, want.channel, chan);
            error_count++;
        end
        if (value !== want.value)
        begin
            $display("%0t: value expected 0x%08h actual 0x%08h", $time, want.value, value);
            error_count++;
        end
        if (last !== want.last)
        begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, last);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                predict_word(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                check_value(m_tdata, m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [WORD_W-1:0] w, input logic l);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tlast  <= l;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
    endtask

    function automatic logic [WORD_W-1:0] random_word();
        logic [WORD_W-1:0] w;
        w = WORD_W'($urandom);
        case ($urandom_range(0, 7))
            0: w = '0;
            1: w = '1;
            2: w[11:0] = VAL_OVERFLOW;
            3: w[11:0] = '0;
            default: ;
        endcase
        return w;
    endfunction

    function automatic void append_section();
        int pick;
        int n;
        pick = $urandom_range(0, 19);
        if (pick < 12)
        begin
            n = $urandom_range(1, CHANNEL_COUNT);
            subevent_words.push_back(pick < 6 ? HDR_ADC : HDR_TDC);
            subevent_words.push_back({1'b1, 3'(n - 1), 12'($urandom)});
            repeat (n)
                subevent_words.push_back(random_word());
        end
        else if (pick < 16)
        begin
            subevent_words.push_back(HDR_SCALER);
            subevent_words.push_back('0);
            repeat (2 + 2 * SCALER_COUNT)
                subevent_words.push_back(random_word());
        end
        else if (pick == 16)
        begin
            subevent_words.push_back($urandom_range(1) ? HDR_ADC : HDR_TDC);
            subevent_words.push_back({1'b0, 15'($urandom)});
        end
        else if (pick == 17)
        begin
            subevent_words.push_back(HDR_SCALER);
            subevent_words.push_back(WORD_W'($urandom_range(1, 65535)));
        end
        else
            subevent_words.push_back(WORD_W'($urandom_range(1, 65535)));
    endfunction

    task automatic send_subevent();
        int ending;
        subevent_words.delete();
        repeat ($urandom_range(1, 3))
            append_section();
        ending = $urandom_range(0, 9);
        if (ending < 2 && subevent_words.size() > 1)
        begin
            repeat ($urandom_range(1, subevent_words.size() - 1))
                void'(subevent_words.pop_back());
        end
        else if (ending < 4)
        begin
            subevent_words.push_back('0);
            repeat ($urandom_range(0, 3))
                subevent_words.push_back(random_word());
            subevent_words.push_back(random_word());
        end
        else if (ending == 4)
            subevent_words.push_back('0);
        foreach (subevent_words[i])
            send_word(subevent_words[i], i == subevent_words.size() - 1);
    endtask

    task automatic test_adc_tdc_sections();
        send_word(16'h0001, 1'b0);
        send_word(HDR_ADC, 1'b0);
        send_word(16'hbfff, 1'b0);
        send_word(16'h7ffe, 1'b0);
        send_word(16'h0fff, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'hffff, 1'b0);
        send_word(HDR_TDC, 1'b0);
        send_word(16'h7fff, 1'b0);
        send_word(HDR_TDC, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'hc123, 1'b1);
    endtask

    task automatic test_scaler_section();
        send_word(HDR_SCALER, 1'b0);
        send_word(16'hffff, 1'b0);
        send_word(HDR_SCALER, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'haaaa, 1'b0);
        send_word(16'h5555, 1'b0);
        send_word(16'hffff, 1'b0);
        send_word(16'hffff, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'h1234, 1'b1);
    endtask

    task automatic test_early_end();
        send_word(HDR_ADC, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'h3456, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(HDR_ADC, 1'b0);
        send_word(16'hffff, 1'b1);
        send_word(16'h0000, 1'b1);
    endtask

    task automatic test_random_subevents(input int n_words, input int idle_pct,
                                         input int hold_pct);
        int target;
        target        = words_sent + n_words;
        send_idle_pct = idle_pct;
        stall_pct     = hold_pct;
        while (words_sent < target)
            send_subevent();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        m_tready      = 1'b0;
        error_count   = 0;
        quiet_cycles  = 0;
        words_sent    = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        skip_to_end   = 1'b0;
        clear_parser();
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        test_adc_tdc_sections();
        test_scaler_section();
        test_early_end();
        test_random_subevents(RANDOM_WORDS, 0, 0);
        test_random_subevents(RANDOM_WORDS, 50, 0);
        test_random_subevents(RANDOM_WORDS, 0, 50);
        test_random_subevents(RANDOM_WORDS, 13, 13);

        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (pending_values.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
design/sdu_pkg.sv
design/sdu_front.sv
design/sdu_cmd_fifo.sv
design/sdu_back.sv
design/detector_subevent_unpacker.sv
sim/detector_subevent_unpacker_tb.sv
